>>> hdl/afs_pkg.sv
`default_nettype none

package afs_pkg;

  localparam int unsigned HDR_BYTES = 9;
  localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_BYTES - 1);
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI_IDX = HDR_IDX_W'(1);
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO_IDX = HDR_IDX_W'(2);
  localparam logic [HDR_IDX_W-1:0] HDR_SEL_IDX = HDR_IDX_W'(6);
  localparam logic [HDR_IDX_W-1:0] HDR_DEST_HI_IDX = HDR_IDX_W'(7);
  localparam logic [HDR_IDX_W-1:0] HDR_MARKER_IDX = HDR_IDX_W'(0);

  localparam logic [15:0] MIN_FRAME_LEN = 16'd11;
  localparam logic [15:0] BROADCAST_SITE = 16'hFFFF;
  localparam logic [7:0] HOST_SELECTOR = 8'd255;

  localparam logic [7:0] OWN_SITE_RST = 8'd10;
  localparam logic [7:0] START_MARKER_RST = 8'hAA;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_SITE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b1;

  // Parser modes
  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_SKIP = 2'd2;
  localparam logic [1:0] MODE_FLUSH = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       datagram_last;
  } afs_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] byte_index;
    logic        frame_last;
    logic        frame_abort;
    logic        reply_to_host;
  } afs_out_t;

endpackage

`default_nettype wire

>>> hdl/addressed_frame_splitter.sv
`default_nettype none

// Channel   | Ports                          | Transfer when
// ----------+--------------------------------+-------------------------------
// input     | in_valid, in_stall, in_data    | in_valid && !in_stall
// result    | out_valid, out_stall, out_data | out_valid && !out_stall
// config    | cfg_we, cfg_index, cfg_wdata   | cfg_we
//
// One datagram byte is taken per cycle while in_stall is low; a byte outside a
// header release gives at most one result, through a two-entry output buffer.
// When a released header completes, its nine bytes leave in order; the input
// is held off until the last of them has been handed to the output buffer.
// out_stall stalls the input only once the output buffer is full.
// Reset (rst_n low, synchronous) returns the parser to header collecting
// and loads own_site = 10, start_marker = 0xAA.
module addressed_frame_splitter
  import afs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata,
  input  wire logic                 in_valid,
  input  afs_in_t                   in_data,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output afs_out_t                  out_data
);

  logic     push_valid;
  logic     push_ready;
  afs_out_t push_data;

  // Parse frames and produce one result transfer per cycle at most
  afs_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // Hold results while the receiver stalls
  afs_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

endmodule

`default_nettype wire

>>> hdl/afs_out_buf.sv
`default_nettype none

module afs_out_buf
  import afs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  input  afs_out_t      push_data,
  output logic          push_ready,
  output logic          out_valid,
  output afs_out_t      out_data,
  input  wire logic     out_stall
);

  logic     out_valid_r;
  afs_out_t out_data_r;
  logic     skid_valid_r;
  afs_out_t skid_data_r;
  logic     out_fire;

  assign out_fire   = out_valid_r && !out_stall;
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (out_fire || !out_valid_r) begin
      out_valid_r <= push_valid;
    end else if (push_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload: move skid into the output slot, take the new transfer, or park it in skid
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (out_fire || !out_valid_r) begin
      if (push_valid) begin
        out_data_r <= push_data;
      end
    end else if (push_valid) begin
      skid_data_r <= push_data;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a pending output");

endmodule

`default_nettype wire

>>> hdl/afs_parser.sv
`default_nettype none

module afs_parser
  import afs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]         cfg_wdata,
  input  wire logic               in_valid,
  input  afs_in_t                 in_data,
  output logic                    in_stall,
  output logic                    push_valid,
  output afs_out_t                push_data,
  input  wire logic               push_ready
);

  logic [7:0]  own_site_r;
  logic [7:0]  start_marker_r;
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic        host_r, host_nxt;
  logic [7:0]  hdr_r [HDR_BYTES];
  logic                 burst_r, burst_nxt;
  logic [HDR_IDX_W-1:0] burst_cnt_r, burst_cnt_nxt;
  logic                 burst_last_r, burst_last_nxt;

  logic                 in_fire;
  logic                 hdr_we;
  logic [HDR_IDX_W-1:0] hpos;
  logic [16:0]          pos_inc;
  logic                 len_done;
  logic [15:0]          hdr_len;
  logic [15:0]          hdr_dest;

  assign in_stall = burst_r || !push_ready;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_site_r     <= OWN_SITE_RST;
      start_marker_r <= START_MARKER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_SITE:     own_site_r <= cfg_wdata;
        REG_START_MARKER: start_marker_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign hpos     = (pos_r >= 16'(HDR_BYTES)) ? '0 : pos_r[HDR_IDX_W-1:0];
  assign pos_inc  = {1'b0, pos_r} + 17'd1;
  assign len_done = pos_inc >= {1'b0, len_r};
  assign hdr_len  = {hdr_r[HDR_LEN_HI_IDX], hdr_r[HDR_LEN_LO_IDX]};
  assign hdr_dest = {hdr_r[HDR_DEST_HI_IDX], in_data.data_byte};

  always_comb begin
    mode_nxt       = mode_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    host_nxt       = host_r;
    burst_nxt      = burst_r;
    burst_cnt_nxt  = burst_cnt_r;
    burst_last_nxt = burst_last_r;
    hdr_we         = 1'b0;
    push_valid     = 1'b0;
    push_data      = '0;

    if (burst_r) begin
      // Release the held header, one byte per cycle while push_ready is high
      if (push_ready) begin
        push_valid              = 1'b1;
        push_data.out_byte      = hdr_r[burst_cnt_r];
        push_data.byte_index    = 16'(burst_cnt_r);
        push_data.frame_last    = (burst_cnt_r == HDR_LAST_IDX) && burst_last_r;
        push_data.frame_abort   = (burst_cnt_r == HDR_LAST_IDX) && burst_last_r;
        push_data.reply_to_host = host_r;
        burst_cnt_nxt           = burst_cnt_r + 1'b1;
        burst_nxt               = burst_cnt_r != HDR_LAST_IDX;
      end
    end else if (in_fire) begin
      unique case (mode_r)
        MODE_HEADER: begin
          hdr_we  = 1'b1;
          pos_nxt = 16'(hpos) + 16'd1;
          if (hpos == HDR_LAST_IDX) begin
            len_nxt  = hdr_len;
            host_nxt = hdr_r[HDR_SEL_IDX] == HOST_SELECTOR;
            priority if (hdr_len < MIN_FRAME_LEN) begin
              mode_nxt = MODE_FLUSH;
            end else if (hdr_dest != {8'd0, own_site_r} && hdr_dest != BROADCAST_SITE) begin
              mode_nxt = MODE_SKIP;
            end else if (hdr_r[HDR_MARKER_IDX] != start_marker_r) begin
              mode_nxt = MODE_FLUSH;
            end else begin
              // Marker goes out now, the other eight bytes follow
              push_valid              = 1'b1;
              push_data.out_byte      = hdr_r[HDR_MARKER_IDX];
              push_data.byte_index    = 16'd0;
              push_data.reply_to_host = host_nxt;
              burst_nxt               = 1'b1;
              burst_cnt_nxt           = HDR_IDX_W'(1);
              burst_last_nxt          = in_data.datagram_last;
              mode_nxt                = MODE_RELEASE;
            end
          end
        end
        MODE_RELEASE: begin
          push_valid              = 1'b1;
          push_data.out_byte      = in_data.data_byte;
          push_data.byte_index    = pos_r;
          push_data.reply_to_host = host_r;
          if (len_done) begin
            push_data.frame_last = 1'b1;
            mode_nxt             = MODE_HEADER;
            pos_nxt              = '0;
          end else if (in_data.datagram_last) begin
            push_data.frame_last  = 1'b1;
            push_data.frame_abort = 1'b1;
          end else begin
            pos_nxt = pos_inc[15:0];
          end
        end
        MODE_SKIP: begin
          if (len_done) begin
            mode_nxt = MODE_HEADER;
            pos_nxt  = '0;
          end else begin
            pos_nxt = pos_inc[15:0];
          end
        end
        MODE_FLUSH: ;
        default: ;
      endcase
      if (in_data.datagram_last) begin
        mode_nxt = MODE_HEADER;
        pos_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HEADER;
      pos_r   <= '0;
      len_r   <= '0;
      host_r  <= 1'b0;
      burst_r <= 1'b0;
      burst_cnt_r  <= '0;
      burst_last_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      host_r  <= host_nxt;
      burst_r <= burst_nxt;
      burst_cnt_r  <= burst_cnt_nxt;
      burst_last_r <= burst_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[hpos] <= in_data.data_byte;
    end
  end

  a_no_accept_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    burst_r |-> !in_fire)
    else $error("input taken while header burst pending");

  a_burst_mode: assert property (@(posedge clk) disable iff (!rst_n)
    burst_r |-> (mode_r == MODE_RELEASE || mode_r == MODE_HEADER))
    else $error("header burst outside release");

  a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HEADER) |-> (pos_r < 16'(HDR_BYTES)))
    else $error("header position beyond header");

endmodule

`default_nettype wire
